@@ rtl/zdat_pkg.sv @@
// ----------------------------------------------------------------------------
// zdat_pkg
// Shared types, constants and helpers for the zoned disk access timer.
// ----------------------------------------------------------------------------
package zdat_pkg;

  localparam int DIV_NW = 64;  // dividend / quotient width
  localparam int DIV_DW = 27;  // divisor / remainder width

  localparam logic [63:0] NS_HALF_REV = 64'd30000000000;
  localparam logic [35:0] NS_FULL_REV = 36'd60000000000;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_IW-1:0] REG_SURFACES  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_TRACKS    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_INNER     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_OUTER     = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SPIN      = 3'd4;
  localparam logic [CFG_IW-1:0] REG_BPS       = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SEEK_FIX  = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SEEK_STEP = 3'd7;

  typedef struct packed {
    logic        opcode;
    logic [63:0] start_time;
    logic [47:0] byte_address;
    logic [31:0] byte_length;
  } req_t;

  typedef struct packed {
    logic [63:0] finish_time;
    logic        beyond_capacity;
  } rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

@@ rtl/zoned_disk_access_timer.sv @@
// ----------------------------------------------------------------------------
// zoned_disk_access_timer
// Times one disk access request on a zoned, multi-surface disk.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_ready) carry opcode, start time, byte address and
// length; output beats (out_valid/out_ready) carry the finish time and the
// beyond-capacity flag, one per request. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data); the user must write it only while the block
// is idle, which the block itself does not enforce. in_ready is high only
// while no request is in flight: one request at a time. A request runs up to
// four setup divisions, walks track by track from track 0 to the start track,
// then times the access chunk by chunk (one cylinder each, two divisions).
// All divisions share one restoring divider. A zero sector size skips them.
// The finished result sits in an output register; if the receiver stalls,
// the next request's result waits until that register is taken.
// Reset (rst, synchronous) loads the default geometry, parks the head on
// track 0 and drops any request in flight.
// ----------------------------------------------------------------------------
module zoned_disk_access_timer #(
  parameter int MAX_TRACKS = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  zdat_pkg::req_t                in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output zdat_pkg::rsp_t                out_data,
  input  logic                          cfg_we,
  input  logic [zdat_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [zdat_pkg::CFG_DW-1:0]   cfg_data
);

  localparam int HW = $clog2(MAX_TRACKS);
  localparam int TW = HW + 1;
  localparam int DW = zdat_pkg::DIV_DW;

  typedef enum logic [3:0] {
    S_IDLE, S_END, S_BEG, S_HALF, S_DELTA, S_ROW, S_CMP,
    S_SIDX, S_SEEK, S_WAITHALF, S_MUL, S_XSTART, S_XWAIT, S_FIN
  } state_t;

  state_t state;

  // configuration
  logic [4:0]  surface_count;
  logic [16:0] track_count;
  logic [11:0] inner_sectors;
  logic [11:0] outer_sectors;
  logic [14:0] spin_rate;
  logic [16:0] bytes_per_sector;
  logic [31:0] seek_fixed_ns;
  logic [19:0] seek_step_ns;

  // work registers
  logic [63:0]        now;
  logic [47:0]        addr_r;
  logic [48:0]        end_q;
  logic [33:0]        rem_cnt;
  logic [34:0]        half_ns;
  logic [47:0]        a_off;
  logic [21:0]        bs;
  logic [14:0]        rpm;
  logic [33:0]        row;
  logic [TW-1:0]      t_idx;
  logic [TW-1:0]      tracks;
  logic [HW-1:0]      span;
  logic [11:0]        n_cur;
  logic [HW-1:0]      r_acc;
  logic signed [13:0] dq;
  logic [HW-1:0]      dr;
  logic [HW-1:0]      head_track;
  logic [19+HW:0]     seek_prod;
  logic [16:0]        max_acc;
  logic [16:0]        arem;
  logic [16:0]        acc;
  logic [52:0]        numer;
  logic [26:0]        xdiv;
  logic               beyond;

  zdat_pkg::div_req_t div_req;
  zdat_pkg::div_rsp_t div_rsp;

  zdat_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // effective track count and sector delta between the zone ends
  logic [TW-1:0] tracks_eff;
  logic [11:0]   delta_abs;
  always_comb begin
    tracks_eff = (track_count > 17'(MAX_TRACKS)) ? TW'(MAX_TRACKS) : TW'(track_count);
    delta_abs  = (outer_sectors >= inner_sectors) ? outer_sectors - inner_sectors
                                                  : inner_sectors - outer_sectors;
  end

  // advance one track: sector count kept as quotient/remainder over span
  logic [HW:0]        step_sum;
  logic               step_wrap;
  logic [HW-1:0]      r_step;
  logic signed [13:0] n_wide;
  always_comb begin
    step_sum  = {1'b0, r_acc} + {1'b0, dr};
    step_wrap = (step_sum >= {1'b0, span});
    r_step    = step_wrap ? HW'(step_sum - {1'b0, span}) : step_sum[HW-1:0];
    n_wide    = $signed({2'b00, n_cur}) + dq + $signed({13'b0, step_wrap});
  end

  logic [HW-1:0] trk_gap;
  logic [16:0]   acc_sel;
  always_comb begin
    trk_gap = (head_track > t_idx[HW-1:0]) ? head_track - t_idx[HW-1:0]
                                           : t_idx[HW-1:0] - head_track;
    acc_sel = (rem_cnt < {17'b0, max_acc}) ? rem_cnt[16:0] : max_acc;
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      head_track       <= '0;
      div_req.start    <= 1'b0;
      surface_count    <= 5'd1;
      track_count      <= 17'd1024;
      inner_sectors    <= 12'd64;
      outer_sectors    <= 12'd128;
      spin_rate        <= 15'd7200;
      bytes_per_sector <= 17'd512;
      seek_fixed_ns    <= 32'd1000000;
      seek_step_ns     <= 20'd1000;
    end else begin
      // start is a one-cycle pulse; no state raises it while it is high
      if (div_req.start) div_req.start <= 1'b0;
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          zdat_pkg::REG_SURFACES:  surface_count    <= cfg_data[4:0];
          zdat_pkg::REG_TRACKS:    track_count      <= cfg_data[16:0];
          zdat_pkg::REG_INNER:     inner_sectors    <= cfg_data[11:0];
          zdat_pkg::REG_OUTER:     outer_sectors    <= cfg_data[11:0];
          zdat_pkg::REG_SPIN:      spin_rate        <= cfg_data[14:0];
          zdat_pkg::REG_BPS:       bytes_per_sector <= cfg_data[16:0];
          zdat_pkg::REG_SEEK_FIX:  seek_fixed_ns    <= cfg_data;
          zdat_pkg::REG_SEEK_STEP: seek_step_ns     <= cfg_data[19:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            now    <= in_data.start_time;
            addr_r <= in_data.byte_address;
            a_off  <= in_data.byte_address;
            bs     <= 22'(bytes_per_sector * surface_count);
            rpm    <= (spin_rate == 15'd0) ? 15'd1 : spin_rate;
            beyond <= (bytes_per_sector == 17'd0);
            if (bytes_per_sector == 17'd0) begin
              state  <= S_FIN;
            end else begin
              div_req.start    <= 1'b1;
              div_req.dividend <= 64'({1'b0, in_data.byte_address} +
                                      49'(in_data.byte_length));
              div_req.divisor  <= DW'(bytes_per_sector);
              state            <= S_END;
            end
          end
        end
        S_END: begin
          if (div_rsp.done) begin
            end_q            <= div_rsp.quot[48:0];
            div_req.start    <= 1'b1;
            div_req.dividend <= 64'(addr_r);
            div_req.divisor  <= DW'(bytes_per_sector);
            state            <= S_BEG;
          end
        end
        S_BEG: begin
          if (div_rsp.done) begin
            rem_cnt          <= 34'(end_q - div_rsp.quot[48:0] + 49'd1);
            div_req.start    <= 1'b1;
            div_req.dividend <= zdat_pkg::NS_HALF_REV;
            div_req.divisor  <= DW'(rpm);
            state            <= S_HALF;
          end
        end
        S_HALF: begin
          if (div_rsp.done) begin
            half_ns <= div_rsp.quot[34:0];
            tracks  <= tracks_eff;
            t_idx   <= '0;
            n_cur   <= inner_sectors;
            r_acc   <= '0;
            if (tracks_eff < TW'(2)) begin
              span  <= HW'(1);
              dq    <= '0;
              dr    <= '0;
              state <= S_ROW;
            end else begin
              span             <= HW'(tracks_eff - TW'(1));
              div_req.start    <= 1'b1;
              div_req.dividend <= 64'(delta_abs);
              div_req.divisor  <= DW'(tracks_eff - TW'(1));
              state            <= S_DELTA;
            end
          end
        end
        S_DELTA: begin
          // floor division of the signed delta by the span
          if (div_rsp.done) begin
            if (outer_sectors >= inner_sectors) begin
              dq <= $signed({1'b0, div_rsp.quot[12:0]});
              dr <= div_rsp.rem[HW-1:0];
            end else if (div_rsp.rem == '0) begin
              dq <= -$signed({1'b0, div_rsp.quot[12:0]});
              dr <= '0;
            end else begin
              dq <= -$signed({1'b0, div_rsp.quot[12:0]}) - 14'sd1;
              dr <= span - div_rsp.rem[HW-1:0];
            end
            state <= S_ROW;
          end
        end
        S_ROW: begin
          if (t_idx >= tracks) begin
            beyond <= 1'b1;
            state  <= S_FIN;
          end else begin
            row   <= 34'(bs * n_cur);
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if ({14'b0, row} > a_off) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= 64'(a_off);
            div_req.divisor  <= DW'(bytes_per_sector);
            state            <= S_SIDX;
          end else begin
            a_off <= a_off - 48'(row);
            t_idx <= t_idx + TW'(1);
            r_acc <= r_step;
            n_cur <= n_wide[11:0];
            state <= S_ROW;
          end
        end
        S_SIDX: begin
          if (div_rsp.done) begin
            arem       <= div_rsp.rem[16:0];
            max_acc    <= 17'(surface_count * n_cur) - div_rsp.quot[16:0];
            seek_prod  <= seek_step_ns * trk_gap;
            head_track <= t_idx[HW-1:0];
            state      <= S_SEEK;
          end
        end
        S_SEEK: begin
          now   <= zdat_pkg::sat_add(now, 64'(seek_fixed_ns) + 64'(seek_prod));
          state <= S_WAITHALF;
        end
        S_WAITHALF: begin
          now     <= zdat_pkg::sat_add(now, 64'(half_ns));
          acc     <= acc_sel;
          rem_cnt <= rem_cnt - 34'(acc_sel);
          state   <= S_MUL;
        end
        S_MUL: begin
          numer <= zdat_pkg::NS_FULL_REV * acc;
          xdiv  <= rpm * n_cur;
          state <= S_XSTART;
        end
        S_XSTART: begin
          div_req.start    <= 1'b1;
          div_req.dividend <= 64'(numer);
          div_req.divisor  <= xdiv;
          state            <= S_XWAIT;
        end
        S_XWAIT: begin
          if (div_rsp.done) begin
            now <= zdat_pkg::sat_add(now, div_rsp.quot);
            if (rem_cnt == '0) begin
              state <= S_FIN;
            end else begin
              // next chunk starts at the sector offset on the next track
              a_off <= 48'(arem);
              t_idx <= t_idx + TW'(1);
              r_acc <= r_step;
              n_cur <= n_wide[11:0];
              state <= S_ROW;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_data.finish_time     <= now;
            out_data.beyond_capacity <= beyond;
            out_valid                <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/zdat_div.sv @@
// ----------------------------------------------------------------------------
// zdat_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zdat_div (
  input  logic               clk,
  input  logic               rst,
  input  zdat_pkg::div_req_t req,
  output zdat_pkg::div_rsp_t rsp
);

  localparam int NW = zdat_pkg::DIV_NW;
  localparam int DW = zdat_pkg::DIV_DW;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   shifted;
  logic [DW:0]   trial;

  always_comb begin
    shifted = {rem, dvd[NW-1]};
    trial   = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      dvd  <= req.dividend;
      dsr  <= req.divisor;
      rem  <= '0;
      cnt  <= CW'(NW);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (!trial[DW]) begin
        rem <= trial[DW-1:0];
        dvd <= {dvd[NW-2:0], 1'b1};
      end else begin
        rem <= shifted[DW-1:0];
        dvd <= {dvd[NW-2:0], 1'b0};
      end
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;
  assign rsp.rem  = rem;

endmodule
